// ----- src/ipe_pkg.sv -----
`timescale 1ns / 1ps
package ipe_pkg;

  localparam int unsigned CoordW = 15;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    REG_STRIDE_ROWS   = 4'd0,
    REG_STRIDE_COLS   = 4'd1,
    REG_DILATION_ROWS = 4'd2,
    REG_DILATION_COLS = 4'd3,
    REG_PAD_TOP       = 4'd4,
    REG_PAD_LEFT      = 4'd5,
    REG_IMAGE_ROWS    = 4'd6,
    REG_IMAGE_COLS    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        operation;
    logic [5:0]  pixel_row;
    logic [5:0]  pixel_col;
    logic [1:0]  pixel_channel;
    logic [31:0] pixel_value;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
  } in_item_t;

  typedef struct packed {
    logic [31:0] element;
    logic        from_padding;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] index;
    logic [6:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [6:0] stride_rows;
    logic [6:0] stride_cols;
    logic [6:0] dilation_rows;
    logic [6:0] dilation_cols;
    logic [5:0] pad_top;
    logic [5:0] pad_left;
    logic [6:0] image_rows;
    logic [6:0] image_cols;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [5:0]  pixel_row;
    logic [5:0]  pixel_col;
    logic [1:0]  pixel_channel;
    logic [31:0] pixel_value;
    coord_t      y0;
    coord_t      x0;
  } cmd_t;

endpackage

// ----- src/ipe_chan_if.sv -----
`timescale 1ns / 1ps
interface ipe_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ipe_front.sv -----
`timescale 1ns / 1ps
module ipe_front
  import ipe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  ipe_chan_if.sink   in_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic [12:0] prod_rows, prod_cols;
  cmd_t       cmd_new;

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    prod_rows = 13'(in_i.data.out_row) * 13'(cfg_i.stride_rows);
    prod_cols = 13'(in_i.data.out_col) * 13'(cfg_i.stride_cols);
    cmd_new.operation     = in_i.data.operation;
    cmd_new.pixel_row     = in_i.data.pixel_row;
    cmd_new.pixel_col     = in_i.data.pixel_col;
    cmd_new.pixel_channel = in_i.data.pixel_channel;
    cmd_new.pixel_value   = in_i.data.pixel_value;
    cmd_new.y0 = $signed({2'b00, prod_rows}) - $signed({9'd0, cfg_i.pad_top});
    cmd_new.x0 = $signed({2'b00, prod_cols}) - $signed({9'd0, cfg_i.pad_left});
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- src/ipe_back.sv -----
`timescale 1ns / 1ps
module ipe_back
  import ipe_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned KERNEL_ROWS = 3,
  parameter int unsigned KERNEL_COLS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  ipe_chan_if.source out_o
);

  localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned KrW   = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
  localparam int unsigned KcW   = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
  localparam int unsigned AddrW = RowW + ColW + ChW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned LimW  = 11;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_EXTRACT = 2'b10
  } state_e;

  state_e     state_q, state_d;
  coord_t     y_q, y_d, x_q, x_d, x0_q, x0_d;
  logic [KrW-1:0] ky_q, ky_d;
  logic [KcW-1:0] kx_q, kx_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic       inflight_q, pad_q, last_q;
  logic [31:0] rdata_q;
  logic [31:0] mem_q [Depth];
  out_item_t  fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic [1:0] occ;
  logic       pop, issue_ok, issue, last_tap, tap_in;
  logic       wr_en, wr_ok, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [6:0] rows_used, cols_used;

  always_comb begin
    rows_used = ({4'd0, cfg_i.image_rows} > LimW'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg_i.image_rows;
    cols_used = ({4'd0, cfg_i.image_cols} > LimW'(MAX_COLS)) ? 7'(MAX_COLS) : cfg_i.image_cols;
    tap_in = !y_q[CoordW-1] && (y_q[CoordW-2:0] < {7'd0, rows_used}) &&
             !x_q[CoordW-1] && (x_q[CoordW-2:0] < {7'd0, cols_used});
    last_tap = (ch_q == ChW'(CHANNELS - 1)) && (kx_q == KcW'(KERNEL_COLS - 1)) &&
               (ky_q == KrW'(KERNEL_ROWS - 1));
  end

  assign pop      = out_o.valid && out_o.ready;
  assign occ      = count_q + {1'b0, inflight_q};
  assign issue_ok = pop ? (occ <= 2'd2) : (occ <= 2'd1);
  assign issue    = (state_q == ST_EXTRACT) && issue_ok;
  assign rd_en    = issue && tap_in;
  assign rd_addr  = {y_q[RowW-1:0], x_q[ColW-1:0], ch_q};

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign wr_ok = ({5'd0, cmd_i.pixel_row} < LimW'(MAX_ROWS)) &&
                 ({5'd0, cmd_i.pixel_col} < LimW'(MAX_COLS)) &&
                 ({1'b0, cmd_i.pixel_channel} < 3'(CHANNELS));
  assign wr_en   = cmd_pop_o && (cmd_i.operation == OP_WRITE) && wr_ok;
  assign wr_addr = {RowW'(cmd_i.pixel_row), ColW'(cmd_i.pixel_col),
                    ChW'(cmd_i.pixel_channel)};

  always_comb begin
    state_d = state_q;
    y_d     = y_q;
    x_d     = x_q;
    x0_d    = x0_q;
    ky_d    = ky_q;
    kx_d    = kx_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && (cmd_i.operation == OP_EXTRACT)) begin
          y_d     = cmd_i.y0;
          x_d     = cmd_i.x0;
          x0_d    = cmd_i.x0;
          ky_d    = '0;
          kx_d    = '0;
          ch_d    = '0;
          state_d = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        if (issue) begin
          if (last_tap) begin
            state_d = ST_IDLE;
          end else if (ch_q != ChW'(CHANNELS - 1)) begin
            ch_d = ch_q + 1'b1;
          end else if (kx_q != KcW'(KERNEL_COLS - 1)) begin
            ch_d = '0;
            kx_d = kx_q + 1'b1;
            x_d  = x_q + $signed({8'd0, cfg_i.dilation_cols});
          end else begin
            ch_d = '0;
            kx_d = '0;
            x_d  = x0_q;
            ky_d = ky_q + 1'b1;
            y_d  = y_q + $signed({8'd0, cfg_i.dilation_rows});
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign count_d = count_q + {1'b0, inflight_q} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      inflight_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      count_q    <= 2'd0;
    end else begin
      state_q    <= state_d;
      inflight_q <= issue;
      wr_ptr_q   <= inflight_q ? ~wr_ptr_q : wr_ptr_q;
      rd_ptr_q   <= pop ? ~rd_ptr_q : rd_ptr_q;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q  <= y_d;
    x_q  <= x_d;
    x0_q <= x0_d;
    ky_q <= ky_d;
    kx_q <= kx_d;
    ch_q <= ch_d;
    if (issue) begin
      pad_q  <= !tap_in;
      last_q <= last_tap;
    end
    if (inflight_q) begin
      fifo_q[wr_ptr_q] <= '{element: (pad_q ? 32'd0 : rdata_q),
                            from_padding: pad_q, last: last_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.pixel_value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid = (count_q != 2'd0);
  assign out_o.data  = fifo_q[rd_ptr_q];

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("result queue overflow");

  a_full_push_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q && count_q == 2'd2) |-> pop) else $error("push into full result queue");

  a_read_in_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == ST_EXTRACT)) else $error("store read outside extract");

  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE)) else $error("command taken while busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_tap) |=> (state_q == ST_IDLE)) else $error("patch did not end");

endmodule

// ----- src/image_patch_extractor_top.sv -----
`timescale 1ns / 1ps
// Write item: taken by the store sequencer while idle, no result.
// Extract item: KERNEL_ROWS*KERNEL_COLS*CHANNELS results, one per cycle while the result
// queue has room, after a load step; results pass the store read register and result queue.
// The store sequencer with its single read port sets the rate; a two-entry command
// queue and a two-entry result queue decouple the channels.
// Reset: async active low; registers to defaults, queues emptied; the store is not cleared.
module image_patch_extractor_top
  import ipe_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned KERNEL_ROWS = 3,
  parameter int unsigned KERNEL_COLS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipe_chan_if.sink   cfg_i,
  ipe_chan_if.sink   in_i,
  ipe_chan_if.source out_o
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stride_rows   <= 7'd1;
      cfg_q.stride_cols   <= 7'd1;
      cfg_q.dilation_rows <= 7'd1;
      cfg_q.dilation_cols <= 7'd1;
      cfg_q.pad_top       <= 6'd0;
      cfg_q.pad_left      <= 6'd0;
      cfg_q.image_rows    <= 7'd64;
      cfg_q.image_cols    <= 7'd64;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_STRIDE_ROWS:   cfg_q.stride_rows   <= cfg_i.data.value;
        REG_STRIDE_COLS:   cfg_q.stride_cols   <= cfg_i.data.value;
        REG_DILATION_ROWS: cfg_q.dilation_rows <= cfg_i.data.value;
        REG_DILATION_COLS: cfg_q.dilation_cols <= cfg_i.data.value;
        REG_PAD_TOP:       cfg_q.pad_top       <= cfg_i.data.value[5:0];
        REG_PAD_LEFT:      cfg_q.pad_left      <= cfg_i.data.value[5:0];
        REG_IMAGE_ROWS:    cfg_q.image_rows    <= cfg_i.data.value;
        REG_IMAGE_COLS:    cfg_q.image_cols    <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  ipe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ipe_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .CHANNELS    (CHANNELS),
    .KERNEL_ROWS (KERNEL_ROWS),
    .KERNEL_COLS (KERNEL_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule

// ----- sim/image_patch_extractor_top_tb.sv -----
`timescale 1ns / 1ps
module image_patch_extractor_top_tb;
  import ipe_pkg::*;

  localparam int MaxRows      = 64;
  localparam int MaxCols      = 64;
  localparam int Channels     = 4;
  localparam int KernelRows   = 3;
  localparam int KernelCols   = 3;
  localparam int PatchLen     = KernelRows * KernelCols * Channels;
  localparam int StoreDepth   = MaxRows * MaxCols * Channels;
  localparam int NumRegs      = 8;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 300;
  localparam int RandomItems  = 200;
  localparam int CalmItems    = 40;
  localparam int PhaseItems   = 34;
  localparam int CycleLimit   = 1000000;

  localparam logic [3:0] RegIdxSpareLo = 4'd8;
  localparam logic [3:0] RegIdxSpareHi = 4'd15;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_EXTRACT,
    ROW_EXTRACT_PAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [3:0]  idx;
    logic [6:0]  val;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [1:0]  chan;
    logic [31:0] value;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipe_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();
  ipe_chan_if #(.payload_t(in_item_t))  in_if ();
  ipe_chan_if #(.payload_t(out_item_t)) out_if ();

  image_patch_extractor_top #(
    .MAX_ROWS   (MaxRows),
    .MAX_COLS   (MaxCols),
    .CHANNELS   (Channels),
    .KERNEL_ROWS(KernelRows),
    .KERNEL_COLS(KernelCols)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t        shadow_cfg;
  logic [31:0] pixel_mem [StoreDepth];
  bit          pixel_written [StoreDepth];
  out_item_t   patch_q [$];
  out_item_t   want;
  int          mismatch_cnt = 0;
  int          sent_items = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  function automatic int pixel_addr(input int y, input int x, input int ch);
    return (y * MaxCols + x) * Channels + ch;
  endfunction

  function automatic bit tap_in_image(input in_item_t it, input int ky, input int kx,
                                      output int y, output int x);
    int rows_used;
    int cols_used;
    rows_used = (shadow_cfg.image_rows > MaxRows) ? MaxRows : int'(shadow_cfg.image_rows);
    cols_used = (shadow_cfg.image_cols > MaxCols) ? MaxCols : int'(shadow_cfg.image_cols);
    y = int'(it.out_row) * int'(shadow_cfg.stride_rows) - int'(shadow_cfg.pad_top)
        + ky * int'(shadow_cfg.dilation_rows);
    x = int'(it.out_col) * int'(shadow_cfg.stride_cols) - int'(shadow_cfg.pad_left)
        + kx * int'(shadow_cfg.dilation_cols);
    return y >= 0 && y < rows_used && x >= 0 && x < cols_used;
  endfunction

  function automatic void predict_patch(input in_item_t it);
    int        y;
    int        x;
    int        n;
    bit        in_img;
    out_item_t e;
    n = 0;
    for (int ky = 0; ky < KernelRows; ky++) begin
      for (int kx = 0; kx < KernelCols; kx++) begin
        in_img = tap_in_image(it, ky, kx, y, x);
        for (int ch = 0; ch < Channels; ch++) begin
          e.element      = in_img ? pixel_mem[pixel_addr(y, x, ch)] : '0;
          e.from_padding = !in_img;
          n++;
          e.last = (n == PatchLen);
          patch_q.push_back(e);
        end
      end
    end
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic step_row_t cfg_row(input logic [3:0] idx, input logic [6:0] val);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic step_row_t pix_row(input logic [5:0] row, input logic [5:0] col,
                                        input logic [1:0] chan, input logic [31:0] value);
    step_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.row = row;
    r.col = col;
    r.chan = chan;
    r.value = value;
    return r;
  endfunction

  function automatic step_row_t ext_row(input logic [5:0] row, input logic [5:0] col,
                                        input bit all_pad);
    step_row_t r;
    r = '0;
    r.kind = all_pad ? ROW_EXTRACT_PAD : ROW_EXTRACT;
    r.row = row;
    r.col = col;
    return r;
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [6:0] val);
    cfg_wr_t w;
    w.index = idx;
    w.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_STRIDE_ROWS:   shadow_cfg.stride_rows   = val;
      REG_STRIDE_COLS:   shadow_cfg.stride_cols   = val;
      REG_DILATION_ROWS: shadow_cfg.dilation_rows = val;
      REG_DILATION_COLS: shadow_cfg.dilation_cols = val;
      REG_PAD_TOP:       shadow_cfg.pad_top       = val[5:0];
      REG_PAD_LEFT:      shadow_cfg.pad_left      = val[5:0];
      REG_IMAGE_ROWS:    shadow_cfg.image_rows    = val;
      REG_IMAGE_COLS:    shadow_cfg.image_cols    = val;
      default: ;
    endcase
  endtask

  task automatic send_item(input in_item_t it, input bit all_pad);
    out_item_t e;
    int        a;
    cfg_if.valid <= 1'b0;
    if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
    if (it.operation == OP_WRITE) begin
      a = pixel_addr(it.pixel_row, it.pixel_col, it.pixel_channel);
      pixel_mem[a] = it.pixel_value;
      pixel_written[a] = 1'b1;
    end else if (all_pad) begin
      for (int n = 1; n <= PatchLen; n++) begin
        e.element      = '0;
        e.from_padding = 1'b1;
        e.last         = (n == PatchLen);
        patch_q.push_back(e);
      end
    end else begin
      predict_patch(it);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (patch_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void flag_mismatch(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    if (mismatch_cnt < 10) begin
      $display("patch %s: expected 0x%08h, got 0x%08h", field, exp_v, got_v);
    end
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (patch_q.size() == 0) begin
        flag_mismatch("element with nothing pending", '0, out_if.data.element);
      end else begin
        want = patch_q.pop_front();
        if (out_if.data.element !== want.element) begin
          flag_mismatch("element", want.element, out_if.data.element);
        end
        if (out_if.data.from_padding !== want.from_padding) begin
          flag_mismatch("from_padding", want.from_padding, out_if.data.from_padding);
        end
        if (out_if.data.last !== want.last) begin
          flag_mismatch("last", want.last, out_if.data.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : result_sink
    int held;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    step_row_t  rows [$];
    in_item_t   it;
    in_item_t   fill;
    bit         prev_item;
    bit         paused;
    bit         wide;
    int         target;
    int         phase;
    int         phase_start;
    int         y;
    int         x;
    logic [6:0] setting;

    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    shadow_cfg   = '{stride_rows: 7'd1, stride_cols: 7'd1, dilation_rows: 7'd1,
                     dilation_cols: 7'd1, pad_top: 6'd0, pad_left: 6'd0,
                     image_rows: 7'd64, image_cols: 7'd64};

    // collapse all taps onto one pixel so a handful of writes backs every read
    rows.push_back(cfg_row(REG_DILATION_ROWS, 7'd0));
    rows.push_back(cfg_row(REG_DILATION_COLS, 7'd0));
    rows.push_back(pix_row(6'd0, 6'd0, 2'd0, 32'h0000_0000));
    rows.push_back(pix_row(6'd0, 6'd0, 2'd1, 32'hFFFF_FFFF));
    rows.push_back(pix_row(6'd0, 6'd0, 2'd2, 32'hA5A5_A5A5));
    rows.push_back(pix_row(6'd0, 6'd0, 2'd3, 32'h5A5A_5A5A));
    rows.push_back(pix_row(6'd63, 6'd63, 2'd0, 32'hFFFF_FFFF));
    rows.push_back(pix_row(6'd63, 6'd63, 2'd1, 32'h0000_0000));
    rows.push_back(pix_row(6'd63, 6'd63, 2'd2, 32'h1234_5678));
    rows.push_back(pix_row(6'd63, 6'd63, 2'd3, 32'h8765_4321));
    rows.push_back(ext_row(6'd0, 6'd0, 1'b0));
    rows.push_back(ext_row(6'd63, 6'd63, 1'b0));
    rows.push_back(cfg_row(REG_PAD_TOP, 7'h7F));
    rows.push_back(cfg_row(REG_PAD_LEFT, 7'h7F));
    rows.push_back(ext_row(6'd0, 6'd0, 1'b1));
    rows.push_back(ext_row(6'd63, 6'd63, 1'b0));
    rows.push_back(cfg_row(REG_PAD_TOP, 7'd0));
    rows.push_back(cfg_row(REG_PAD_LEFT, 7'd0));
    rows.push_back(cfg_row(REG_STRIDE_ROWS, 7'h7F));
    rows.push_back(cfg_row(REG_STRIDE_COLS, 7'h7F));
    rows.push_back(ext_row(6'd1, 6'd1, 1'b1));
    rows.push_back(ext_row(6'd0, 6'd0, 1'b0));
    rows.push_back(cfg_row(REG_IMAGE_ROWS, 7'd0));
    rows.push_back(ext_row(6'd0, 6'd0, 1'b1));
    rows.push_back(cfg_row(REG_IMAGE_ROWS, 7'h7F));
    rows.push_back(cfg_row(REG_IMAGE_COLS, 7'h7F));
    rows.push_back(cfg_row(RegIdxSpareLo, 7'h7F));
    rows.push_back(cfg_row(RegIdxSpareHi, 7'd0));
    rows.push_back(ext_row(6'd63, 6'd63, 1'b1));
    rows.push_back(ext_row(6'd0, 6'd0, 1'b0));
    rows.push_back(cfg_row(REG_STRIDE_ROWS, 7'd0));
    rows.push_back(cfg_row(REG_STRIDE_COLS, 7'd0));
    rows.push_back(ext_row(6'd63, 6'd63, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    prev_item = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (prev_item) wait_drained();
        write_reg(rows[i].idx, rows[i].val);
        prev_item = 1'b0;
      end else begin
        it = random_item();
        if (rows[i].kind == ROW_WRITE) begin
          it.operation     = OP_WRITE;
          it.pixel_row     = rows[i].row;
          it.pixel_col     = rows[i].col;
          it.pixel_channel = rows[i].chan;
          it.pixel_value   = rows[i].value;
        end else begin
          it.operation = OP_EXTRACT;
          it.out_row   = rows[i].row;
          it.out_col   = rows[i].col;
        end
        send_item(it, rows[i].kind == ROW_EXTRACT_PAD);
        prev_item = 1'b1;
      end
    end

    target = sent_items + RandomItems;
    phase = 0;
    while (sent_items < target) begin
      wait_drained();
      for (int i = 0; i < NumRegs; i++) begin
        case ($urandom_range(0, 9))
          0: setting = 7'($urandom);
          1: setting = '0;
          2: setting = '1;
          3: setting = 7'd64;
          default: begin
            case (4'(i))
              REG_STRIDE_ROWS, REG_STRIDE_COLS: setting = 7'($urandom_range(1, 4));
              REG_IMAGE_ROWS, REG_IMAGE_COLS:   setting = 7'($urandom_range(1, 12));
              default:                          setting = 7'($urandom_range(0, 3));
            endcase
          end
        endcase
        write_reg(4'(i), setting);
      end
      if ($urandom_range(0, 2) == 0) write_reg({1'b1, 3'($urandom)}, 7'($urandom));

      calm        = (target - sent_items <= CalmItems);
      idle_on     = ($urandom_range(0, 3) != 0);
      hold_req    = (phase == 1);
      paused      = 1'b0;
      phase_start = sent_items;
      while (sent_items - phase_start < PhaseItems) begin
        if (phase == 2 && !paused && sent_items - phase_start >= PhaseItems / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        it = random_item();
        if ($urandom_range(0, 4) == 0) begin
          it.operation = OP_WRITE;
          send_item(it, 1'b0);
        end else begin
          wide         = ($urandom_range(0, 3) == 0);
          it.operation = OP_EXTRACT;
          it.out_row   = 6'($urandom_range(0, wide ? 63 : 7));
          it.out_col   = 6'($urandom_range(0, wide ? 63 : 7));
          // load every pixel the patch reads that holds no value yet
          for (int ky = 0; ky < KernelRows; ky++) begin
            for (int kx = 0; kx < KernelCols; kx++) begin
              if (tap_in_image(it, ky, kx, y, x)) begin
                for (int ch = 0; ch < Channels; ch++) begin
                  if (!pixel_written[pixel_addr(y, x, ch)]) begin
                    fill               = random_item();
                    fill.operation     = OP_WRITE;
                    fill.pixel_row     = 6'(y);
                    fill.pixel_col     = 6'(x);
                    fill.pixel_channel = 2'(ch);
                    send_item(fill, 1'b0);
                  end
                end
              end
            end
          end
          send_item(it, 1'b0);
        end
      end
      phase++;
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
